/* design/fcr_pkg.sv */
package fcr_pkg;

  // Sizing
  localparam int unsigned MAX_LEN_DEF = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame bytes
  localparam logic [7:0] PFX_A        = 8'hAA;
  localparam logic [7:0] PFX_B        = 8'h55;
  localparam logic [7:0] RSP_ACK_B    = 8'h80;
  localparam logic [7:0] RSP_ERR_B    = 8'h81;
  localparam logic [7:0] RSP_STATUS_B = 8'h82;

  // Command codes
  localparam logic [7:0] CMD_MODE    = 8'h01;
  localparam logic [7:0] CMD_STOP    = 8'h02;
  localparam logic [7:0] CMD_FWD     = 8'h03;
  localparam logic [7:0] CMD_BACK    = 8'h04;
  localparam logic [7:0] CMD_LEFT    = 8'h05;
  localparam logic [7:0] CMD_RIGHT   = 8'h06;
  localparam logic [7:0] CMD_MIX     = 8'h07;
  localparam logic [7:0] CMD_TURN    = 8'h08;
  localparam logic [7:0] CMD_DMAX    = 8'h09;
  localparam logic [7:0] CMD_STATUS  = 8'h0A;
  localparam logic [7:0] CMD_HOLD    = 8'h40;
  localparam logic [7:0] CMD_FREE    = 8'h41;

  // Actuation kinds
  localparam logic [3:0] KIND_NONE   = 4'd0;
  localparam logic [3:0] KIND_STOP   = 4'd3;
  localparam logic [3:0] KIND_MIX    = 4'd8;
  localparam logic [3:0] KIND_TURN   = 4'd9;
  localparam logic [3:0] KIND_DMAX   = 4'd11;
  localparam logic [3:0] KIND_LOCK   = 4'd12;
  localparam logic [3:0] KIND_UNLOCK = 4'd13;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_ARG  = 3'd1;
  localparam logic [2:0] ERR_BAD_MODE = 3'd2;
  localparam logic [2:0] ERR_NOT_CAR  = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd4;

  localparam logic [1:0] MODE_WHEELED = 2'd1;

  typedef enum logic [2:0] {
    PH_WAIT_A,
    PH_WAIT_B,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    REPLY_ACK,
    REPLY_ERR,
    REPLY_STATUS
  } reply_t;

  // One queued reply with its actuation command
  typedef struct packed {
    reply_t            kind;
    logic [2:0]        err_code;
    logic [1:0]        mode;
    logic              cmd_valid;
    logic [3:0]        cmd_kind;
    logic              cancel_run;
    logic [15:0]       arg_value;
    logic signed [7:0] left_pct;
    logic signed [7:0] right_pct;
  } reply_desc_t;

endpackage

/* design/framed_command_receiver.sv */
// Receives a byte stream one beat per cycle and hunts for frames
// AA 55 LEN CMD payload CHK, where CHK is the XOR of LEN through the payload.
// Frames with a LEN of zero or above MAX_LEN are dropped, frames with a bad
// check produce nothing. A good frame produces one reply of 6 beats (ACK or
// ERR) or 11 beats (STATUS); the actuation command rides on the first reply
// beat and tlast marks the reply's check byte. The input side takes one beat
// every cycle; it stalls only on a frame's check byte while the four-entry
// reply queue is full. The output side sends one reply beat per cycle while
// out_ready is high, back to back across replies, so sustained throughput is
// set by reply length against incoming frame length. A decoded reply is queued
// and then loaded into the output register before it reaches the output.
module framed_command_receiver import fcr_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [9:8] current_mode, [15:10] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] tx_byte, [8] cmd_valid, [12:9] cmd_kind,
                                  // [13] cancel_run, [29:14] arg_value,
                                  // [37:30] left_pct, [45:38] right_pct, [47:46] zero
  output logic        out_tlast
);

  reply_desc_t       push_desc, head_desc;
  logic              push, pop, q_full, q_empty;
  logic [7:0]        tx_byte;
  logic              cmd_valid, cancel_run;
  logic [3:0]        cmd_kind;
  logic [15:0]       arg_value;
  logic signed [7:0] left_pct, right_pct;

  fcr_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .rx_byte      (in_tdata[7:0]),
    .current_mode (in_tdata[9:8]),
    .queue_full   (q_full),
    .push         (push),
    .push_desc    (push_desc)
  );

  fcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .full      (q_full),
    .empty     (q_empty)
  );

  fcr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_desc   (head_desc),
    .queue_empty (q_empty),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .tx_byte     (tx_byte),
    .last_byte   (out_tlast),
    .cmd_valid   (cmd_valid),
    .cmd_kind    (cmd_kind),
    .cancel_run  (cancel_run),
    .arg_value   (arg_value),
    .left_pct    (left_pct),
    .right_pct   (right_pct)
  );

  // Pack the result beat
  assign out_tdata = {2'b00, right_pct, left_pct, arg_value, cancel_run, cmd_kind,
                      cmd_valid, tx_byte};

endmodule

/* design/fcr_front.sv */
module fcr_front import fcr_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic [1:0]  current_mode,
  input  logic        queue_full,
  output logic        push,
  output reply_desc_t push_desc
);

  phase_t      phase_r, phase_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic [7:0]  head_r [3];
  logic        fire;
  logic [5:0]  idx_inc;
  logic        len_bad;
  logic        chk_good;
  logic [5:0]  n_args;
  logic [7:0]  cmd, p0, p1;
  logic [15:0] word;
  reply_desc_t dec;

  function automatic logic signed [7:0] clamp_pct(input logic [7:0] raw);
    logic signed [7:0] v;
    v = signed'(raw);
    if (v < -8'sd100) return -8'sd100;
    if (v > 8'sd100) return 8'sd100;
    return v;
  endfunction

  assign in_ready = !(phase_r == PH_CHECK && queue_full);
  assign fire     = in_valid && in_ready;
  assign idx_inc  = idx_r + 6'd1;
  assign len_bad  = (rx_byte == 8'd0) || (rx_byte > 8'(MAX_LEN));
  assign chk_good = (rx_byte == chk_r) && (len_r != 6'd0);

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        PH_WAIT_A: phase_nxt = (rx_byte == PFX_A) ? PH_WAIT_B : PH_WAIT_A;
        PH_WAIT_B: phase_nxt = (rx_byte == PFX_B) ? PH_LEN : PH_WAIT_A;
        PH_LEN:    phase_nxt = len_bad ? PH_WAIT_A : PH_DATA;
        PH_DATA:   phase_nxt = (idx_inc == len_r) ? PH_CHECK : PH_DATA;
        PH_CHECK:  phase_nxt = PH_WAIT_A;
        default:   phase_nxt = PH_WAIT_A;
      endcase
    end
  end

  // Length, index, running check and push
  always_comb begin
    len_nxt = len_r;
    idx_nxt = idx_r;
    chk_nxt = chk_r;
    push    = 1'b0;
    if (fire) begin
      unique case (phase_r)
        PH_LEN: begin
          idx_nxt = 6'd0;
          chk_nxt = rx_byte;
          len_nxt = len_bad ? 6'd0 : rx_byte[5:0];
        end
        PH_DATA: begin
          chk_nxt = chk_r ^ rx_byte;
          idx_nxt = idx_inc;
        end
        PH_CHECK: push = chk_good;
        default: ;
      endcase
    end
  end

  // Decode the held frame head
  assign cmd    = head_r[0];
  assign p0     = head_r[1];
  assign p1     = head_r[2];
  assign word   = {p1, p0};
  assign n_args = len_r - 6'd1;

  always_comb begin
    dec = '{kind: REPLY_ACK, err_code: ERR_NONE, mode: current_mode, cmd_valid: 1'b1,
           cmd_kind: KIND_NONE, cancel_run: 1'b0, arg_value: 16'd0,
           left_pct: 8'sd0, right_pct: 8'sd0};
    unique case (cmd) inside
      CMD_MODE: begin
        if (n_args != 6'd1) dec.err_code = ERR_BAD_ARG;
        else if (p0 > 8'd2) dec.err_code = ERR_BAD_MODE;
        else dec.cmd_kind = {2'b00, p0[1:0]};
      end
      CMD_STOP: dec.cmd_kind = KIND_STOP;
      CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT: begin
        if (n_args != 6'd1) dec.err_code = ERR_BAD_ARG;
        else if (current_mode != MODE_WHEELED) dec.err_code = ERR_NOT_CAR;
        else begin
          dec.cmd_kind   = cmd[3:0] + 4'd1;
          dec.cancel_run = 1'b1;
          dec.arg_value  = (p0 > 8'd100) ? 16'd100 : {8'd0, p0};
        end
      end
      CMD_MIX: begin
        if (n_args != 6'd2) dec.err_code = ERR_BAD_ARG;
        else if (current_mode != MODE_WHEELED) dec.err_code = ERR_NOT_CAR;
        else begin
          dec.cmd_kind   = KIND_MIX;
          dec.cancel_run = 1'b1;
          dec.left_pct   = clamp_pct(p0);
          dec.right_pct  = clamp_pct(p1);
        end
      end
      CMD_TURN: begin
        if (n_args != 6'd1 || p0 > 8'd1) dec.err_code = ERR_BAD_ARG;
        else dec.cmd_kind = KIND_TURN + {3'd0, p0[0]};
      end
      CMD_DMAX: begin
        if (n_args != 6'd2) dec.err_code = ERR_BAD_ARG;
        else begin
          dec.cmd_kind = KIND_DMAX;
          if (word < 16'd200) dec.arg_value = 16'd200;
          else if (word > 16'd500) dec.arg_value = 16'd500;
          else dec.arg_value = word;
        end
      end
      CMD_STATUS: begin
        dec.kind      = REPLY_STATUS;
        dec.cmd_valid = 1'b0;
      end
      CMD_HOLD: begin
        dec.cmd_kind  = KIND_LOCK;
        dec.arg_value = (n_args >= 6'd2) ? word : 16'd1000;
      end
      CMD_FREE: dec.cmd_kind = KIND_UNLOCK;
      default: dec.err_code = ERR_UNKNOWN;
    endcase
    // Errors carry no actuation
    if (dec.err_code != ERR_NONE) begin
      dec.kind       = REPLY_ERR;
      dec.cmd_valid  = 1'b0;
      dec.cmd_kind   = KIND_NONE;
      dec.cancel_run = 1'b0;
      dec.arg_value  = 16'd0;
      dec.left_pct   = 8'sd0;
      dec.right_pct  = 8'sd0;
    end
  end

  assign push_desc = dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_A;
      len_r   <= 6'd0;
      idx_r   <= 6'd0;
      chk_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      chk_r   <= chk_nxt;
    end
  end

  // Capture command and first two payload bytes
  always_ff @(posedge clk) begin
    if (fire && phase_r == PH_DATA && idx_r < 6'd3) begin
      head_r[idx_r[1:0]] <= rx_byte;
    end
  end

endmodule

/* design/fcr_queue.sv */
module fcr_queue import fcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  reply_desc_t push_desc,
  input  logic        pop,
  output reply_desc_t head_desc,
  output logic        full,
  output logic        empty
);

  reply_desc_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_desc = mem[rd_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_nxt  = do_push ? QPTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop ? QPTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_desc;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("reply pushed into full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

endmodule

/* design/fcr_back.sv */
module fcr_back import fcr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  reply_desc_t       head_desc,
  input  logic              queue_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        tx_byte,
  output logic              last_byte,
  output logic              cmd_valid,
  output logic [3:0]        cmd_kind,
  output logic              cancel_run,
  output logic [15:0]       arg_value,
  output logic signed [7:0] left_pct,
  output logic signed [7:0] right_pct
);

  localparam logic [7:0] LEN_ACK    = 8'h01;
  localparam logic [7:0] LEN_ERR    = 8'h02;
  localparam logic [7:0] LEN_STATUS = 8'h06;
  localparam logic [7:0] DMAX_LO    = 8'h90;
  localparam logic [7:0] DMAX_HI    = 8'h01;
  localparam logic [3:0] LAST_SHORT = 4'd5;
  localparam logic [3:0] LAST_LONG  = 4'd10;

  reply_desc_t cur_r;
  logic        busy_r, busy_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  last_idx;
  logic        beat;
  logic        done;
  logic        first;
  logic [7:0]  body;

  assign last_idx  = (cur_r.kind == REPLY_STATUS) ? LAST_LONG : LAST_SHORT;
  assign out_valid = busy_r;
  assign beat      = busy_r && out_ready;
  assign last_byte = busy_r && (idx_r == last_idx);
  assign done      = beat && last_byte;
  assign pop       = !queue_empty && (!busy_r || done);
  assign first     = busy_r && (idx_r == 4'd0);

  // Reply byte for the current position
  always_comb begin
    body = 8'h00;
    unique case (cur_r.kind)
      REPLY_ACK: begin
        case (idx_r)
          4'd2:    body = LEN_ACK;
          4'd3:    body = RSP_ACK_B;
          4'd4:    body = 8'h01;
          4'd5:    body = LEN_ACK ^ RSP_ACK_B ^ 8'h01;
          default: body = 8'h00;
        endcase
      end
      REPLY_ERR: begin
        case (idx_r)
          4'd2:    body = LEN_ERR;
          4'd3:    body = RSP_ERR_B;
          4'd4:    body = {5'd0, cur_r.err_code};
          4'd5:    body = LEN_ERR ^ RSP_ERR_B ^ {5'd0, cur_r.err_code};
          default: body = 8'h00;
        endcase
      end
      REPLY_STATUS: begin
        case (idx_r)
          4'd2:    body = LEN_STATUS;
          4'd3:    body = RSP_STATUS_B;
          4'd4:    body = {6'd0, cur_r.mode};
          4'd7:    body = DMAX_LO;
          4'd8:    body = DMAX_HI;
          4'd10:   body = LEN_STATUS ^ RSP_STATUS_B ^ {6'd0, cur_r.mode} ^ DMAX_LO ^ DMAX_HI;
          default: body = 8'h00;
        endcase
      end
      default: body = 8'h00;
    endcase
  end

  // Prefix bytes are common to every reply
  always_comb begin
    case (idx_r)
      4'd0:    tx_byte = PFX_A;
      4'd1:    tx_byte = PFX_B;
      default: tx_byte = body;
    endcase
  end

  // Command fields ride on the first beat only
  assign cmd_valid  = first && cur_r.cmd_valid;
  assign cmd_kind   = first ? cur_r.cmd_kind : 4'd0;
  assign cancel_run = first && cur_r.cancel_run;
  assign arg_value  = first ? cur_r.arg_value : 16'd0;
  assign left_pct   = first ? cur_r.left_pct : 8'sd0;
  assign right_pct  = first ? cur_r.right_pct : 8'sd0;

  // Advance through the reply, load the next one on its last beat or when idle
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 4'd0;
    end else if (done) begin
      busy_nxt = 1'b0;
      idx_nxt  = 4'd0;
    end else if (beat) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_desc;
    end
  end

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !last_byte) |=> (busy_r && idx_r == $past(idx_r) + 4'd1))
    else $error("reply index did not advance by one");

  a_cmd_first: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && idx_r != 4'd0) |-> (!cmd_valid && !cancel_run && arg_value == 16'd0))
    else $error("command fields outside first reply beat");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    last_byte |-> (idx_r == LAST_SHORT || idx_r == LAST_LONG))
    else $error("reply ends at wrong length");

endmodule
